>>> rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg: shared types and constants of the stochastic bitstream multiplier
// Holds field widths, operand decoding and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int unsigned RAW_W       = 20;
    localparam int unsigned CFG_W       = 5;
    localparam int unsigned OUT_W       = 21;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned FRAC_BITS   = 24;

    localparam int unsigned STREAM_WORDS_DEF = 16384;
    localparam int unsigned WORD_BITS_DEF    = 32;

    localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(20);
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(20);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP_RUN,
        ST_STEP_CHECK,
        ST_COUNT_RUN,
        ST_FINISH
    } t_state;

    typedef enum logic {
        DIV_STEP,
        DIV_COUNT
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_step;
        logic     cap_count;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic step_small;
        logic div_done;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] mag;
    } t_operand;

    // Clamp the configured width into the supported range.
    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] res;
        res = w;
        if (w < WIDTH_MIN) res = WIDTH_MIN;
        if (w > WIDTH_MAX) res = WIDTH_MAX;
        return res;
    endfunction

    // Sign-extend the low w bits of raw and split into sign and magnitude.
    function automatic t_operand decode_operand(input logic [RAW_W-1:0] raw,
                                                input logic [CFG_W-1:0] w);
        logic [RAW_W:0] mask;
        logic [RAW_W:0] v;
        logic [RAW_W:0] sbit;
        logic [RAW_W:0] neg_v;
        t_operand       res;
        mask  = ~({(RAW_W+1){1'b1}} << w);
        v     = {1'b0, raw} & mask;
        sbit  = (RAW_W+1)'(1) << (w - CFG_W'(1));
        neg_v = (~v + (RAW_W+1)'(1)) & mask;
        if ((v & sbit) != '0) begin
            res.neg = 1'b1;
            res.mag = neg_v[RAW_W-1:0];
        end else begin
            res.neg = 1'b0;
            res.mag = v[RAW_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/sbm_divider.sv
// ----------------------------------------------------------------------------
// sbm_divider: iterative restoring divider
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module sbm_divider #(
    parameter int unsigned W = 46
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    trial;

    assign trial = {r_rem, r_quo[W-1]};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = W'(trial - {1'b0, r_div});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath: operand decode, step and count division, output register
// Acts on controller commands and reports status back.
// ----------------------------------------------------------------------------
module sbm_datapath
    import sbm_pkg::*;
#(
    parameter int unsigned STREAM_WORDS = STREAM_WORDS_DEF,
    parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    input  logic [IN_TDATA_W-1:0] i_in_data,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic [OUT_W-1:0]      o_out_data
);

    localparam int unsigned STREAM_BITS = STREAM_WORDS * WORD_BITS;
    localparam int unsigned LW          = $clog2(STREAM_BITS + 1);
    localparam int unsigned NW          = LW + FRAC_BITS + 2;

    localparam logic [NW-1:0] L_FIX    = NW'(STREAM_BITS);
    localparam logic [NW-1:0] HALF_M1  = NW'((1 << (FRAC_BITS - 1)) - 1);

    logic [CFG_W-1:0] r_width;
    logic [RAW_W-1:0] r_mag_a, r_mag_b;
    logic             r_neg;
    logic [LW-1:0]    r_m;
    logic [NW-1:0]    r_step;
    logic             r_step_small;
    logic [OUT_W-1:0] r_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_operand         op_a, op_b;
    logic [CFG_W-1:0] eff_w;
    logic [NW-1:0]    div_dividend, div_divisor, div_quotient;
    logic             div_done;
    logic [NW-1:0]    mb_wide;

    assign eff_w = clamp_width(r_width);
    assign op_a  = decode_operand(i_in_data[RAW_W-1:0], eff_w);
    assign op_b  = decode_operand(i_in_data[2*RAW_W-1:RAW_W], eff_w);
    assign mb_wide = NW'(r_mag_b);

    always_comb begin
        if (i_cmd.div_sel == DIV_STEP) begin
            div_dividend = (L_FIX << (FRAC_BITS + 1)) + NW'(r_mag_a);
            div_divisor  = NW'({r_mag_a, 1'b0});
        end else begin
            div_dividend = (NW'(r_m) << FRAC_BITS) + HALF_M1;
            div_divisor  = r_step;
        end
    end

    sbm_divider #(
        .W (NW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag_a <= op_a.mag;
            r_mag_b <= op_b.mag;
            r_neg   <= op_a.neg ^ op_b.neg;
            r_count <= '0;
        end
        // The second stream cannot run past the end of the stream.
        if (i_cmd.div_start && i_cmd.div_sel == DIV_STEP) begin
            r_m <= (mb_wide > L_FIX) ? LW'(STREAM_BITS) : LW'(r_mag_b);
        end
        if (i_cmd.cap_step) begin
            r_step       <= div_quotient;
            r_step_small <= (div_quotient >> FRAC_BITS) == '0;
            if ((div_quotient >> FRAC_BITS) == '0) begin
                r_count <= OUT_W'(r_m);
            end
        end
        if (i_cmd.cap_count) begin
            r_count <= div_quotient[OUT_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_data <= r_neg ? (~r_count + OUT_W'(1)) : r_count;
        end
    end

    assign o_status.zero       = (r_mag_a == '0) || (r_mag_b == '0);
    assign o_status.step_small = r_step_small;
    assign o_status.div_done   = div_done;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl: sequencing state machine
// Orders the step division, the count division and the hand-off of a result.
// ----------------------------------------------------------------------------
module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.zero ? ST_FINISH : ST_STEP_RUN;
            end
            ST_STEP_RUN: begin
                if (i_status.div_done) n_state = ST_STEP_CHECK;
            end
            ST_STEP_CHECK: begin
                n_state = i_status.step_small ? ST_FINISH : ST_COUNT_RUN;
            end
            ST_COUNT_RUN: begin
                if (i_status.div_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = DIV_STEP;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.div_start = !i_status.zero;
            end
            ST_STEP_RUN: begin
                o_cmd.cap_step = i_status.div_done;
            end
            ST_STEP_CHECK: begin
                o_cmd.div_start = !i_status.step_small;
                o_cmd.div_sel   = DIV_COUNT;
            end
            ST_COUNT_RUN: begin
                o_cmd.div_sel   = DIV_COUNT;
                o_cmd.cap_count = i_status.div_done;
            end
            ST_FINISH: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/stochastic_bitstream_multiplier.sv
// ----------------------------------------------------------------------------
// stochastic_bitstream_multiplier: unipolar stochastic AND multiplier
// The bit-serial divider sets the pace; it runs at most twice per item, and
// a new beat is accepted only once the previous result has been written to
// the output register. NW = clog2(STREAM_WORDS*WORD_BITS + 1) + 26. Items
// with a zero operand skip both divisions.
// Reset (synchronous, active low) empties the output register, returns the
// sequencer to idle and sets operand_width to 20.
// ----------------------------------------------------------------------------
//
// The count of ones in the AND of the two streams has a closed form. The
// first stream has a one at round(k*step) for k = 1, 2, ..., and the second
// stream has ones in positions 1..m, with m the second magnitude capped at the
// stream length. Because the rounded positions strictly increase once the
// step is at least one, the count is the number of k whose rounded position
// does not exceed m, which is floor(limit / step) with
// limit = m*2^24 + 2^23 - 1 in the same fixed point as step.
//
// So each item runs two divisions through one shared restoring divider:
// first step = (L*2^25 + |a|) / (2*|a|), then count = limit / step. When the
// step falls below one, every position up to m holds a one and the count is m.
// If either magnitude is zero, the count is zero and no division runs.
//
// A result waits in the output register; the next beat can be accepted and
// worked on while it waits, and only the hand-off of that next result stalls.
module stochastic_bitstream_multiplier
    import sbm_pkg::*;
#(
    parameter int unsigned STREAM_WORDS = STREAM_WORDS_DEF,
    parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration: operand_width.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [19:0] lhs_raw, [39:20] rhs_raw
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [20:0] product, [23:21] zero
);

    t_cmd             cmd;
    t_status          status;
    logic [OUT_W-1:0] out_data;

    sbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sbm_datapath #(
        .STREAM_WORDS (STREAM_WORDS),
        .WORD_BITS    (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (out_data)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - OUT_W)'(0), out_data};

endmodule

>>> tb/stochastic_product_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stochastic_product_checker: result predictor and scoreboard
// Tracks operand_width from the configuration port, predicts the signed count
// of ones for every accepted operand beat and compares result beats in order.
// ----------------------------------------------------------------------------
module stochastic_product_checker
    import sbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   i_op_tvalid,
    input  logic                   i_op_tready,
    input  logic [IN_TDATA_W-1:0]  i_op_tdata,    // [19:0] lhs_raw, [39:20] rhs_raw
    input  logic                   i_res_tvalid,
    input  logic                   i_res_tready,
    input  logic [OUT_TDATA_W-1:0] i_res_tdata,   // [20:0] product, [23:21] zero
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [63:0] STREAM_LEN = 64'(STREAM_WORDS_DEF) * 64'(WORD_BITS_DEF);
    localparam logic [63:0] UNIT       = 64'(1) << FRAC_BITS;
    localparam logic [63:0] HALF_UNIT  = 64'(1) << (FRAC_BITS - 1);

    logic [CFG_W-1:0] width_copy;
    logic [OUT_W-1:0] expected_products [$];

    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] mag;
    } t_signed_mag;

    // Two's complement value of the low w bits, split into sign and magnitude.
    function automatic t_signed_mag split_operand(input logic [RAW_W-1:0] raw,
                                                  input logic [CFG_W-1:0] w);
        logic [RAW_W-1:0] mask;
        logic [RAW_W-1:0] sign_bit;
        logic [RAW_W-1:0] v;
        t_signed_mag      res;
        mask     = RAW_W'((21'(1) << w) - 21'(1));
        sign_bit = RAW_W'(1) << (w - CFG_W'(1));
        v        = raw & mask;
        res.neg  = (v & sign_bit) != '0;
        res.mag  = res.neg ? ((~v + RAW_W'(1)) & mask) : v;
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] predict_product(input logic [IN_TDATA_W-1:0] beat,
                                                         input logic [CFG_W-1:0] w_cfg);
        logic [CFG_W-1:0] w;
        t_signed_mag      a;
        t_signed_mag      b;
        logic [63:0]      span;
        logic [63:0]      step;
        logic [63:0]      ones;
        w = w_cfg;
        if (w < CFG_W'(2)) w = CFG_W'(2);
        if (w > CFG_W'(20)) w = CFG_W'(20);
        a = split_operand(beat[RAW_W-1:0], w);
        b = split_operand(beat[2*RAW_W-1:RAW_W], w);
        if (a.mag == '0 || b.mag == '0) begin
            ones = '0;
        end else begin
            // The second stream can never hold more ones than the stream has bits.
            span = 64'(b.mag);
            if (span > STREAM_LEN) span = STREAM_LEN;
            step = ((STREAM_LEN << (FRAC_BITS + 1)) + 64'(a.mag)) / (64'(a.mag) * 64'd2);
            if (step < UNIT) begin
                ones = span;
            end else begin
                ones = ((span + 64'd1) * UNIT - HALF_UNIT - 64'd1) / step;
            end
        end
        return (a.neg != b.neg) ? OUT_W'(-ones) : OUT_W'(ones);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        width_copy   = WIDTH_RESET;
    end

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            width_copy = WIDTH_RESET;
            expected_products.delete();
        end else begin
            if (i_cfg_wr_en) width_copy = i_cfg_wr_data;
            if (i_op_tvalid && i_op_tready)
                expected_products.push_back(predict_product(i_op_tdata, width_copy));
            if (i_res_tvalid && i_res_tready) begin
                if (expected_products.size() == 0) begin
                    $error("product: expected no beat, got %0d",
                           $signed(i_res_tdata[OUT_W-1:0]));
                    o_fail_count++;
                end else begin
                    want = expected_products.pop_front();
                    if (i_res_tdata[OUT_W-1:0] !== want) begin
                        $error("product: expected %0d, got %0d", $signed(want),
                               $signed(i_res_tdata[OUT_W-1:0]));
                        o_fail_count++;
                    end
                    if (i_res_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
                        $error("padding: expected 0, got %0h",
                               i_res_tdata[OUT_TDATA_W-1:OUT_W]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_products.size();
    end

endmodule

>>> tb/tb_stochastic_bitstream_multiplier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stochastic_bitstream_multiplier: stimulus and verdict
// Drives operand beats through several operand widths with random idling on
// both streams; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_stochastic_bitstream_multiplier;
    import sbm_pkg::*;

    // Number of random beats sent in each width phase.
    localparam int RANDOM_PER_PHASE = 8;
    // Cycles to keep watching after the last expected beat; longer than
    // the block's latency so a stray extra result would still be caught.
    localparam int DRAIN_CYCLES = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [19:0] lhs_raw, [39:20] rhs_raw
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [20:0] product, [23:21] zero

    int   fail_count;
    int   pending;
    // While set, neither side idles: one whole phase runs at full pressure.
    logic calm = 1'b0;

    // Widths visited after reset. Values below 2 and above 20 exercise the
    // clamping, and 31 toggles every bit of the register.
    logic [CFG_W-1:0] width_plan [10] = '{5'd2, 5'd0, 5'd1, 5'd31, 5'd21,
                                          5'd19, 5'd8, 5'd12, 5'd5, 5'd20};

    // Directed operand pairs at the reset width of 20 bits: zero operands with
    // either sign on the other side, the most negative value (whose magnitude
    // fills the whole stream), the largest positive value, minus one, and
    // raw values whose upper bits would be discarded at narrower widths.
    logic [RAW_W-1:0] directed_lhs [16] = '{
        20'h00000, 20'h00000, 20'h7FFFF, 20'h80000, 20'h80000, 20'h7FFFF,
        20'h7FFFF, 20'h00001, 20'h00001, 20'hFFFFF, 20'hFFFFF, 20'h80000,
        20'h00003, 20'h55555, 20'hAAAAA, 20'h00001};
    logic [RAW_W-1:0] directed_rhs [16] = '{
        20'h00000, 20'h7FFFF, 20'h00000, 20'h80000, 20'h7FFFF, 20'h80000,
        20'h7FFFF, 20'h00001, 20'hFFFFF, 20'hFFFFF, 20'h00001, 20'h00000,
        20'h12345, 20'hAAAAA, 20'h55555, 20'h7FFFF};

    stochastic_bitstream_multiplier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stochastic_product_checker i_product_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op_tvalid   (s_axis_tvalid),
        .i_op_tready   (s_axis_tready),
        .i_op_tdata    (s_axis_tdata),
        .i_res_tvalid  (m_axis_tvalid),
        .i_res_tready  (m_axis_tready),
        .i_res_tdata   (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls with a probability of 37 percent, except during
    // the calm phase.
    always @(negedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // Width that the block actually uses for a programmed register value.
    function automatic logic [CFG_W-1:0] used_width(input logic [CFG_W-1:0] w);
        if (w < CFG_W'(2)) return CFG_W'(2);
        if (w > CFG_W'(20)) return CFG_W'(20);
        return w;
    endfunction

    // Random operand: either fully random raw bits, a small value of either
    // sign, or a value next to the edges of the current width.
    function automatic logic [RAW_W-1:0] pick_operand(input logic [CFG_W-1:0] w);
        logic [RAW_W-1:0] sign_bit;
        logic [RAW_W-1:0] tiny;
        sign_bit = RAW_W'(1) << (w - CFG_W'(1));
        tiny     = RAW_W'($urandom_range(8));
        case ($urandom_range(3))
            0: return $urandom_range(1) ? tiny : -tiny;
            1: return sign_bit + RAW_W'($urandom_range(2)) - RAW_W'(1);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Offers one operand beat, possibly after a random gap, and returns on the
    // falling edge after it was taken. tvalid is left high so that the next
    // beat can follow back to back; the caller lowers it when it pauses.
    task automatic send_operands(input logic [RAW_W-1:0] lhs, input logic [RAW_W-1:0] rhs);
        while (!calm && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rhs, lhs};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stops offering beats and waits until every result has come back, so the
    // block is idle; every beat yields a result, so nothing else is in flight.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] w_eff;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset width of 20 bits: the directed pairs first.
        for (int i = 0; i < 16; i++) send_operands(directed_lhs[i], directed_rhs[i]);

        for (int p = 0; p < 10; p++) begin
            drain_results();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= width_plan[p];
            @(negedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            calm          <= (p == 5);
            w_eff = used_width(width_plan[p]);
            // At every width, the most negative value against itself and
            // against the largest positive value, then random beats.
            send_operands(RAW_W'(1) << (w_eff - CFG_W'(1)),
                          RAW_W'(1) << (w_eff - CFG_W'(1)));
            send_operands((RAW_W'(1) << (w_eff - CFG_W'(1))) - RAW_W'(1),
                          RAW_W'(1) << (w_eff - CFG_W'(1)));
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_operands(pick_operand(w_eff), pick_operand(w_eff));
        end

        drain_results();
        calm <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_stochastic_bitstream_multiplier: clean");
        end else begin
            $display("tb_stochastic_bitstream_multiplier: errors");
        end
        $finish;
    end

    // Watchdog: the whole run needs well under a tenth of this time.
    initial begin
        #5ms;
        $display("tb_stochastic_bitstream_multiplier: errors");
        $finish;
    end

endmodule
